@@ hw/rtl/hrbt_pkg.sv @@
// Shared types, codes and byte-classification functions of the HTTP request byte tokenizer.
// Depends on nothing; the front, queue, back and top-level modules import it.
package hrbt_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_QKEY    = 4'd2,
        PH_QVAL    = 4'd3,
        PH_VERSION = 4'd4,
        PH_HNAME   = 4'd5,
        PH_HVLEAD  = 4'd6,
        PH_HVALUE  = 4'd7,
        PH_BODY    = 4'd8,
        PH_ERROR   = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        K_METHOD  = 4'd0,
        K_PATH    = 4'd1,
        K_QKEY    = 4'd2,
        K_QVAL    = 4'd3,
        K_VERSION = 4'd4,
        K_HNAME   = 4'd5,
        K_HVALUE  = 4'd6,
        K_BODY    = 4'd7,
        K_DELIM   = 4'd8,
        K_DROP    = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        B_NONE         = 4'd0,
        B_METHOD_END   = 4'd1,
        B_PATH_END     = 4'd2,
        B_QKEY_END     = 4'd3,
        B_PAIR_END     = 4'd4,
        B_REQLINE_END  = 4'd5,
        B_HNAME_END    = 4'd6,
        B_HLINE_END    = 4'd7,
        B_HLINE_DROP   = 4'd8,
        B_HEADERS_END  = 4'd9
    } t_bnd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_REQLINE = 2'd1,
        ST_NO_METHOD  = 2'd2,
        ST_NO_URI     = 2'd3
    } t_status;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_bnd       bnd;
        logic       last;
        t_status    status;
    } t_res;

    // Parser context carried from byte to byte.
    typedef struct packed {
        t_phase  phase;
        logic    colon;
        logic    empty;
        t_status err;
    } t_ctx;

    // Everything one input byte produces, if it yields any: one or two results.
    typedef struct packed {
        logic pair;
        t_res first;
        t_res second;
    } t_rec;

    typedef struct packed {
        t_ctx ctx;
        t_res res;
    } t_byte_step;

    typedef struct packed {
        t_ctx ctx;
        t_res cr;
        t_res lf;
    } t_crlf_step;

    localparam t_ctx CTX_RESET = '{phase: PH_METHOD, colon: 1'b0, empty: 1'b1, err: ST_OK};

    function automatic t_res mk_res(logic [7:0] b, t_kind k, t_bnd d);
        t_res r;
        r.data   = b;
        r.kind   = k;
        r.bnd    = d;
        r.last   = 1'b0;
        r.status = ST_OK;
        return r;
    endfunction

    // Classifies one byte that is not part of a CRLF.
    function automatic t_byte_step take_byte(t_ctx c, logic [7:0] b);
        t_byte_step s;
        s.ctx = c;
        s.res = mk_res(b, K_DROP, B_NONE);
        case (c.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    s.ctx.phase = PH_PATH;
                    s.res = mk_res(b, K_DELIM, B_METHOD_END);
                end else begin
                    s.res = mk_res(b, K_METHOD, B_NONE);
                end
            end
            PH_PATH: begin
                if (b == CH_SP) begin
                    s.ctx.phase = PH_VERSION;
                    s.res = mk_res(b, K_DELIM, B_PATH_END);
                end else if (b == CH_QMARK) begin
                    s.ctx.phase = PH_QKEY;
                    s.res = mk_res(b, K_DELIM, B_PATH_END);
                end else begin
                    s.res = mk_res(b, K_PATH, B_NONE);
                end
            end
            PH_QKEY: begin
                if (b == CH_SP) begin
                    s.ctx.phase = PH_VERSION;
                    s.res = mk_res(b, K_DELIM, B_PAIR_END);
                end else if (b == CH_AMP) begin
                    s.res = mk_res(b, K_DELIM, B_PAIR_END);
                end else if (b == CH_EQ) begin
                    s.ctx.phase = PH_QVAL;
                    s.res = mk_res(b, K_DELIM, B_QKEY_END);
                end else begin
                    s.res = mk_res(b, K_QKEY, B_NONE);
                end
            end
            PH_QVAL: begin
                if (b == CH_SP) begin
                    s.ctx.phase = PH_VERSION;
                    s.res = mk_res(b, K_DELIM, B_PAIR_END);
                end else if (b == CH_AMP) begin
                    s.ctx.phase = PH_QKEY;
                    s.res = mk_res(b, K_DELIM, B_PAIR_END);
                end else begin
                    s.res = mk_res(b, K_QVAL, B_NONE);
                end
            end
            PH_VERSION: s.res = mk_res(b, K_VERSION, B_NONE);
            PH_HNAME: begin
                s.ctx.empty = 1'b0;
                if (b == CH_COLON) begin
                    s.ctx.colon = 1'b1;
                    s.ctx.phase = PH_HVLEAD;
                    s.res = mk_res(b, K_DELIM, B_HNAME_END);
                end else begin
                    s.res = mk_res(b, K_HNAME, B_NONE);
                end
            end
            PH_HVLEAD: begin
                if (b == CH_SP) begin
                    s.res = mk_res(b, K_DELIM, B_NONE);
                end else begin
                    s.ctx.phase = PH_HVALUE;
                    s.res = mk_res(b, K_HVALUE, B_NONE);
                end
            end
            PH_HVALUE: s.res = mk_res(b, K_HVALUE, B_NONE);
            PH_BODY:   s.res = mk_res(b, K_BODY, B_NONE);
            default:   s.res = mk_res(b, K_DROP, B_NONE);
        endcase
        return s;
    endfunction

    // Handles a held CR that turned out to be followed by LF.
    function automatic t_crlf_step take_crlf(t_ctx c);
        t_crlf_step s;
        t_bnd       d;
        s.ctx = c;
        d     = B_NONE;
        if (c.phase inside {PH_METHOD, PH_PATH, PH_QKEY, PH_QVAL}) begin
            s.ctx.err   = (c.phase == PH_METHOD) ? ST_NO_METHOD : ST_NO_URI;
            s.ctx.phase = PH_ERROR;
            s.cr = mk_res(CH_CR, K_DROP, B_NONE);
            s.lf = mk_res(CH_LF, K_DROP, B_NONE);
        end else begin
            if (c.phase == PH_VERSION) begin
                d = B_REQLINE_END;
                s.ctx.phase = PH_HNAME;
            end else if (c.colon) begin
                d = B_HLINE_END;
                s.ctx.phase = PH_HNAME;
            end else if (c.empty) begin
                d = B_HEADERS_END;
                s.ctx.phase = PH_BODY;
            end else begin
                d = B_HLINE_DROP;
                s.ctx.phase = PH_HNAME;
            end
            s.ctx.colon = 1'b0;
            s.ctx.empty = 1'b1;
            s.cr = mk_res(CH_CR, K_DELIM, B_NONE);
            s.lf = mk_res(CH_LF, K_DELIM, d);
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/http_request_byte_tokenizer_unit.sv @@
// Top level of the HTTP request byte tokenizer.
// Depends on hrbt_pkg, hrbt_front, hrbt_queue and hrbt_back.
//
// Usage: raw request bytes enter on the input channel (i_valid, o_stall) with
// i_end_of_data marking the final byte of a request. Each byte is tagged with a
// token kind and, on separators, a boundary code; results leave on the output
// channel (o_valid, i_stall), one per cycle while i_stall is low.
// Throughput: one byte per cycle while o_stall is low. A byte yields zero, one or
// two results: a CR that might start a CRLF is held and yields nothing, and the
// byte after it yields two, or one if it is itself a CR that is held in turn. The
// output register delivers one result per cycle while i_stall is low, so pairs
// are absorbed by the four-record queue. Each result passes through the queue and
// then the output register; a pair's second result follows from that register.
// Stall: when the receiver raises i_stall the output holds; the queue fills and
// o_stall rises once it holds four records. Acceptance never waits on the output
// register directly.
// Reset: i_rst_n is synchronous and active low. It empties the queue and the
// output register and returns the parser to the start of a request. After the
// final byte of each request the parser likewise starts over by itself.
module http_request_byte_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_kind,
    output logic [3:0] o_boundary,
    output logic       o_last_result,
    output logic [1:0] o_status
);
    import hrbt_pkg::*;

    // Front to queue.
    logic push;
    t_rec push_rec;
    logic q_full;
    // Queue to back.
    logic q_not_empty;
    logic pop;
    t_rec pop_rec;
    t_res res;

    hrbt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .i_full        (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    hrbt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rec       (push_rec),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_rec       (pop_rec)
    );

    hrbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (q_not_empty),
        .i_rec       (pop_rec),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (res)
    );

    // The result register drives the payload ports field by field.
    assign o_out_byte    = res.data;
    assign o_kind        = res.kind;
    assign o_boundary    = res.bnd;
    assign o_last_result = res.last;
    assign o_status      = res.status;

endmodule

@@ hw/rtl/hrbt_front.sv @@
// Front part of the tokenizer: accepts input bytes, runs the parser context and
// builds a record of 1-2 results per byte that yields any. Depends on hrbt_pkg.
module hrbt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_data,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output hrbt_pkg::t_rec o_rec
);
    import hrbt_pkg::*;

    t_ctx       r_ctx, n_ctx;
    logic       r_held, n_held;
    logic       accept;
    logic       has_res;
    t_byte_step s0, s1, s2;
    t_crlf_step sx;
    t_rec       rec;
    t_status    st;

    assign o_stall = i_full;
    assign accept  = i_valid & ~i_full;

    always_comb begin
        s0 = take_byte(r_ctx, i_data_byte);
        s1 = take_byte(r_ctx, CH_CR);
        s2 = take_byte(s1.ctx, i_data_byte);
        sx = take_crlf(r_ctx);
        n_ctx   = r_ctx;
        n_held  = 1'b0;
        has_res = 1'b1;
        rec.pair   = 1'b0;
        rec.first  = s0.res;
        rec.second = s2.res;
        if (r_held) begin
            if (i_data_byte == CH_LF) begin
                n_ctx      = sx.ctx;
                rec.pair   = 1'b1;
                rec.first  = sx.cr;
                rec.second = sx.lf;
            end else begin
                rec.first = s1.res;
                if (i_data_byte == CH_CR && !i_end_of_data && s1.ctx.phase < PH_BODY) begin
                    n_ctx  = s1.ctx;
                    n_held = 1'b1;
                end else begin
                    n_ctx    = s2.ctx;
                    rec.pair = 1'b1;
                end
            end
        end else if (i_data_byte == CH_CR && !i_end_of_data && r_ctx.phase < PH_BODY) begin
            n_held  = 1'b1;
            has_res = 1'b0;
        end else begin
            n_ctx = s0.ctx;
        end

        // The final byte closes the request: tag its last result and start over.
        if (n_ctx.err != ST_OK) begin
            st = n_ctx.err;
        end else if (n_ctx.phase <= PH_VERSION) begin
            st = ST_NO_REQLINE;
        end else begin
            st = ST_OK;
        end
        if (i_end_of_data) begin
            if (rec.pair) begin
                rec.second.last   = 1'b1;
                rec.second.status = st;
            end else begin
                rec.first.last   = 1'b1;
                rec.first.status = st;
            end
            n_ctx  = CTX_RESET;
            n_held = 1'b0;
        end
    end

    assign o_push = accept & has_res;
    assign o_rec  = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx  <= CTX_RESET;
            r_held <= 1'b0;
        end else if (accept) begin
            r_ctx  <= n_ctx;
            r_held <= n_held;
        end
    end

endmodule

@@ hw/rtl/hrbt_queue.sv @@
// Short record queue between the front and back parts of the tokenizer.
// Depends on hrbt_pkg for the record type and depth.
module hrbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrbt_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_not_empty,
    output hrbt_pkg::t_rec o_rec
);
    import hrbt_pkg::*;

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_pop;

    assign o_full      = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_rec       = r_mem[r_rd];
    assign do_pop      = i_pop & o_not_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/hrbt_back.sv @@
// Back part of the tokenizer (depends on hrbt_pkg): takes records from the queue
// and delivers their results from an output register, one per unstalled cycle.
module hrbt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_not_empty,
    input  hrbt_pkg::t_rec i_rec,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output hrbt_pkg::t_res o_res
);
    import hrbt_pkg::*;

    t_rec r_rec;
    logic r_valid, n_valid;
    logic r_sel, n_sel;
    logic out_take;
    logic done;

    assign out_take = r_valid & ~i_stall;
    // The current record is finished once its only or its second result is taken.
    assign done  = out_take & (r_sel | ~r_rec.pair);
    assign o_pop = i_not_empty & (~r_valid | done);

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (o_pop) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
        end else if (done) begin
            n_valid = 1'b0;
            n_sel   = 1'b0;
        end else if (out_take) begin
            n_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_sel ? r_rec.second : r_rec.first;

endmodule
